/* rtl/lbvh_pkg.sv */
// Package for the LBVH radix tree node builder: widths, opcodes, sequencer states
// and the IEEE single ordered compare used by the box union. No dependencies.
`default_nettype none
package lbvh_pkg;
   localparam int MaxLeavesDefault = 1024;
   localparam int KeyWidth = 32;
   localparam int CountWidth = 11;

   localparam logic OpWriteLeaf = 1'b0;
   localparam logic OpBuildNode = 1'b1;

   typedef enum logic [3:0] {
      StIdle,
      StDirRead,
      StDirWait,
      StExpRead,
      StExpWait,
      StBinRead,
      StBinWait,
      StEndRead,
      StEndWait,
      StSplitRead,
      StSplitWait,
      StBoxRead,
      StBoxWait,
      StDone
   } state_type;

   // True when a < b as IEEE singles; false whenever either is a NaN.
   function automatic logic fp_less(input logic [31:0] a, input logic [31:0] b);
      logic a_nan;
      logic b_nan;
      logic both_zero;
      logic res;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
      if (a_nan || b_nan || both_zero) begin
         res = 1'b0;
      end else if (a[31] != b[31]) begin
         res = a[31];
      end else if (!a[31]) begin
         res = a[30:0] < b[30:0];
      end else begin
         res = a[30:0] > b[30:0];
      end
      return res;
   endfunction

   // Leading zero count of a 32-bit word, 32 for zero.
   function automatic logic [5:0] clz32(input logic [31:0] v);
      logic [5:0] c;
      logic found;
      c = 6'd32;
      found = 1'b0;
      for (int i = 31; i >= 0; i--) begin
         if (!found && v[i]) begin
            c = 6'(31 - i);
            found = 1'b1;
         end
      end
      return c;
   endfunction
endpackage
`default_nettype wire

/* rtl/lbvh_leaf_mem.sv */
// Leaf storage for the LBVH node builder: key memory and box memory, one write
// port and one registered read port each. Depends on lbvh_pkg.
`default_nettype none
module lbvh_leaf_mem
   import lbvh_pkg::*;
#(
   parameter int MAX_LEAVES = MaxLeavesDefault,
   localparam int AW = $clog2(MAX_LEAVES)
) (
   input  wire logic           clock,
   input  wire logic           wr_en,
   input  wire logic [AW-1:0]  wr_addr,
   input  wire logic [31:0]    wr_key,
   input  wire logic [191:0]   wr_box,
   input  wire logic [AW-1:0]  key_addr,
   output logic      [31:0]    key_data,
   input  wire logic [AW-1:0]  box_addr,
   output logic      [191:0]   box_data
);
   logic [31:0]  key_mem [MAX_LEAVES];
   logic [191:0] box_mem [MAX_LEAVES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         box_mem[wr_addr] <= wr_box;
      end
      key_data <= key_mem[key_addr];
      box_data <= box_mem[box_addr];
   end
endmodule
`default_nettype wire

/* rtl/lbvh_radix_tree_node_builder_core.sv */
// Top level of the LBVH radix tree node builder: request decode, search sequencer and box
// union. Depends on lbvh_pkg and lbvh_leaf_mem.
// A leaf write is accepted in idle and leaves busy low. A node build keeps busy high through the
// search and box union states, every key or box read taking a read state and a wait state; a
// bad index keeps it high for one cycle.
// The result strobe follows in the cycle busy falls and cannot be stalled. Reset sets leaf_count to 2.
`default_nettype none
module lbvh_radix_tree_node_builder_core
   import lbvh_pkg::*;
#(
   parameter int MAX_LEAVES = MaxLeavesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [10:0] csr_wdata,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_op,
   input  wire logic [9:0]  req_index,
   input  wire logic [31:0] req_key,
   input  wire logic [31:0] req_lo_x,
   input  wire logic [31:0] req_lo_y,
   input  wire logic [31:0] req_lo_z,
   input  wire logic [31:0] req_hi_x,
   input  wire logic [31:0] req_hi_y,
   input  wire logic [31:0] req_hi_z,
   output logic             rsp_valid,
   output logic [9:0]       rsp_node_id,
   output logic [9:0]       rsp_range_first,
   output logic [9:0]       rsp_range_last,
   output logic [9:0]       rsp_split_at,
   output logic [31:0]      rsp_box_lo_x,
   output logic [31:0]      rsp_box_lo_y,
   output logic [31:0]      rsp_box_lo_z,
   output logic [31:0]      rsp_box_hi_x,
   output logic [31:0]      rsp_box_hi_y,
   output logic [31:0]      rsp_box_hi_z,
   output logic             rsp_bad_index
);
   localparam int AW = $clog2(MAX_LEAVES);
   localparam int SW = 18;  // signed index arithmetic, covers up to 65536 leaves

   state_type state_ff, state_in;
   logic [10:0] count_ff, count_in;
   logic signed [SW-1:0] idx_ff, idx_in, n_ff, n_in;
   logic signed [SW-1:0] d_ff, d_in, lmax_ff, lmax_in, l_ff, l_in, t_ff, t_in;
   logic signed [SW-1:0] first_ff, first_in, last_ff, last_in, split_ff, split_in;
   logic signed [SW-1:0] step_ff, step_in, ptr_ff, ptr_in, probe_ff, probe_in;
   logic signed [7:0] dmin_ff, dmin_in, dnext_ff, dnext_in, common_ff, common_in;
   logic [31:0] key_i_ff, key_i_in, key_f_ff, key_f_in;
   logic [1:0] sub_ff, sub_in;
   logic [191:0] box_ff, box_in;
   logic bad_ff, bad_in, valid_ff, valid_in, eq_ff, eq_in;

   logic [31:0] key_data;
   logic [191:0] box_data;
   logic [AW-1:0] key_addr, box_addr;
   logic accept, probe_ok;
   logic signed [SW-1:0] n_eff, probe_calc;
   logic signed [7:0] plen;

   assign accept = start && !busy;

   lbvh_leaf_mem #(.MAX_LEAVES(MAX_LEAVES)) u_mem (
      .clock(clock),
      .wr_en(accept && req_op == OpWriteLeaf && 32'(req_index) < MAX_LEAVES),
      .wr_addr(AW'(req_index)),
      .wr_key(req_key),
      .wr_box({req_hi_z, req_hi_y, req_hi_x, req_lo_z, req_lo_y, req_lo_x}),
      .key_addr(key_addr),
      .key_data(key_data),
      .box_addr(box_addr),
      .box_data(box_data)
   );

   always_comb begin
      if (count_ff < 11'd2) n_eff = SW'(2);
      else if (32'(count_ff) > MAX_LEAVES) n_eff = SW'(MAX_LEAVES);
      else n_eff = SW'(count_ff);
   end

   // probe validity and prefix length of key_data against the node key
   assign probe_ok = (probe_ff >= 0) && (probe_ff < n_ff);
   always_comb begin
      if (!probe_ok) plen = -8'sd1;
      else if (key_data == key_i_ff)
         plen = 8'd32 + 8'(clz32(32'(idx_ff ^ probe_ff)));
      else plen = 8'(clz32(key_data ^ key_i_ff));
   end

   always_comb begin
      key_addr = AW'(probe_ff);
      box_addr = AW'(ptr_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StIdle: if (accept && req_op == OpBuildNode) begin
            if (SW'(req_index) >= n_eff - 1) state_in = StDone;
            else state_in = StDirRead;
         end
         StDirRead: state_in = StDirWait;
         StDirWait: if (sub_ff == 2'd2) state_in = StExpRead;
            else state_in = StDirRead;
         StExpRead: state_in = StExpWait;
         StExpWait: if (plen > dmin_ff) state_in = StExpRead;
            else state_in = StBinRead;
         StBinRead: state_in = StBinWait;
         StBinWait: if (t_ff <= 1) state_in = StEndRead;
            else state_in = StBinRead;
         StEndRead: state_in = StEndWait;
         StEndWait: if (sub_ff == 2'd1) state_in = eq_in ? StBoxRead : StSplitRead;
            else state_in = StEndRead;
         StSplitRead: state_in = StSplitWait;
         StSplitWait: if (step_ff <= 1) state_in = StBoxRead;
            else state_in = StSplitRead;
         StBoxRead: state_in = StBoxWait;
         StBoxWait: if (ptr_ff >= last_ff) state_in = StDone;
            else state_in = StBoxRead;
         StDone: state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   // datapath
   always_comb begin
      logic signed [SW-1:0] cand, nstep;
      logic [31:0] lo0, lo1, lo2, hi0, hi1, hi2;
      count_in = csr_we ? csr_wdata : count_ff;
      idx_in = idx_ff; n_in = n_ff; d_in = d_ff; lmax_in = lmax_ff; l_in = l_ff;
      t_in = t_ff; first_in = first_ff; last_in = last_ff; split_in = split_ff;
      step_in = step_ff; ptr_in = ptr_ff; probe_in = probe_ff; dmin_in = dmin_ff;
      dnext_in = dnext_ff; common_in = common_ff; key_i_in = key_i_ff;
      key_f_in = key_f_ff; sub_in = sub_ff; box_in = box_ff; bad_in = bad_ff;
      eq_in = eq_ff; valid_in = 1'b0;
      probe_calc = '0; cand = '0; nstep = '0;
      lo0 = '0; lo1 = '0; lo2 = '0; hi0 = '0; hi1 = '0; hi2 = '0;
      case (state_ff)
         StIdle: if (accept && req_op == OpBuildNode) begin
            idx_in = SW'(req_index);
            n_in = n_eff;
            bad_in = SW'(req_index) >= n_eff - 1;
            probe_in = SW'(req_index);
            sub_in = 2'd0;
            first_in = '0; last_in = '0; split_in = '0; box_in = '0;
         end
         StDirWait: begin
            case (sub_ff)
               2'd0: begin
                  key_i_in = key_data;
                  probe_in = SW'(idx_ff + 1);
               end
               2'd1: begin
                  dnext_in = plen;
                  probe_in = SW'(idx_ff - 1);
               end
               default: begin
                  if (dnext_ff - plen < 0) begin
                     d_in = SW'(-1); dmin_in = dnext_ff;
                     probe_in = SW'(idx_ff - 2);
                  end else begin
                     d_in = SW'(1); dmin_in = plen;
                     probe_in = SW'(idx_ff + 2);
                  end
                  lmax_in = SW'(2);
               end
            endcase
            sub_in = sub_ff + 2'd1;
         end
         StExpWait: begin
            if (plen > dmin_ff) begin
               lmax_in = lmax_ff <<< 1;
               probe_in = idx_ff + (lmax_ff <<< 1) * d_ff;
            end else begin
               l_in = '0;
               t_in = lmax_ff >>> 1;
               probe_in = idx_ff + (lmax_ff >>> 1) * d_ff;
            end
         end
         StBinWait: begin
            cand = l_ff;
            if (plen > dmin_ff) cand = l_ff + t_ff;
            l_in = cand;
            t_in = t_ff >>> 1;
            probe_in = idx_ff + (cand + (t_ff >>> 1)) * d_ff;
            if (t_ff <= 1) begin
               probe_calc = idx_ff + cand * d_ff;
               first_in = (idx_ff < probe_calc) ? idx_ff : probe_calc;
               last_in = (idx_ff < probe_calc) ? probe_calc : idx_ff;
               probe_in = (idx_ff < probe_calc) ? idx_ff : probe_calc;
               sub_in = 2'd0;
            end
         end
         StEndWait: begin
            if (sub_ff == 2'd0) begin
               key_f_in = key_data;
               probe_in = last_ff;
               sub_in = 2'd1;
            end else begin
               eq_in = key_data == key_f_ff;
               common_in = 8'(clz32(key_data ^ key_f_ff));
               split_in = first_ff;
               nstep = SW'((last_ff - first_ff + 1) >>> 1);
               step_in = nstep;
               probe_in = first_ff + nstep;
               if (key_data == key_f_ff) split_in = (first_ff + last_ff) >>> 1;
               ptr_in = first_ff;
            end
         end
         StSplitWait: begin
            cand = split_ff;
            if (probe_ff < last_ff && 8'(clz32(key_f_ff ^ key_data)) > common_ff)
               cand = probe_ff;
            split_in = cand;
            nstep = SW'((step_ff + 1) >>> 1);
            step_in = nstep;
            probe_in = cand + nstep;
         end
         StBoxWait: begin
            lo0 = box_data[31:0]; lo1 = box_data[63:32]; lo2 = box_data[95:64];
            hi0 = box_data[127:96]; hi1 = box_data[159:128]; hi2 = box_data[191:160];
            if (ptr_ff != first_ff) begin
               if (!fp_less(lo0, box_ff[31:0])) lo0 = box_ff[31:0];
               if (!fp_less(lo1, box_ff[63:32])) lo1 = box_ff[63:32];
               if (!fp_less(lo2, box_ff[95:64])) lo2 = box_ff[95:64];
               if (!fp_less(box_ff[127:96], hi0)) hi0 = box_ff[127:96];
               if (!fp_less(box_ff[159:128], hi1)) hi1 = box_ff[159:128];
               if (!fp_less(box_ff[191:160], hi2)) hi2 = box_ff[191:160];
            end
            box_in = {hi2, hi1, hi0, lo2, lo1, lo0};
            ptr_in = SW'(ptr_ff + 1);
         end
         StDone: valid_in = 1'b1;
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      busy = state_ff != StIdle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         count_ff <= 11'd2;
         valid_ff <= 1'b0;
         sub_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         sub_ff <= sub_in;
      end
      idx_ff <= idx_in; n_ff <= n_in; d_ff <= d_in; lmax_ff <= lmax_in; l_ff <= l_in;
      t_ff <= t_in; first_ff <= first_in; last_ff <= last_in; split_ff <= split_in;
      step_ff <= step_in; ptr_ff <= ptr_in; probe_ff <= probe_in; dmin_ff <= dmin_in;
      dnext_ff <= dnext_in; common_ff <= common_in; key_i_ff <= key_i_in;
      key_f_ff <= key_f_in; box_ff <= box_in; bad_ff <= bad_in; eq_ff <= eq_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_node_id = 10'(idx_ff);
   assign rsp_range_first = 10'(first_ff);
   assign rsp_range_last = 10'(last_ff);
   assign rsp_split_at = 10'(split_ff);
   assign rsp_box_lo_x = box_ff[31:0];
   assign rsp_box_lo_y = box_ff[63:32];
   assign rsp_box_lo_z = box_ff[95:64];
   assign rsp_box_hi_x = box_ff[127:96];
   assign rsp_box_hi_y = box_ff[159:128];
   assign rsp_box_hi_z = box_ff[191:160];
   assign rsp_bad_index = bad_ff;

   a_strobe_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StDone) |=> rsp_valid)
      else $error("result strobe missing after done");
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bad_index) |-> (rsp_range_first <= rsp_range_last))
      else $error("range out of order");
   a_split_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bad_index) |->
      (rsp_split_at >= rsp_range_first && rsp_split_at <= rsp_range_last))
      else $error("split outside range");
endmodule
`default_nettype wire
